// ===== src/hrd_pkg.sv =====
`default_nettype none

package hrd_pkg;

    // Depth of the code tree store; a power of two so that positions wrap by masking.
    localparam int TREE_WORDS = 1024;
    localparam int TREE_AW    = $clog2(TREE_WORDS);

    // Input word layout on s_axis_tdata.
    localparam int IN_DATA_W  = 40;
    localparam int IDX_LSB    = 0;
    localparam int WORD_LSB   = 10;
    localparam int BYTE_LSB   = 26;

    // Output word layout on m_axis_tdata.
    localparam int OUT_DATA_W = 24;

    // Low bytes of a control leaf seen in literal mode.
    localparam logic [7:0] ARM_COUNT15 = 8'h00;
    localparam logic [7:0] ARM_COUNT16 = 8'h01;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_DECODE = 1'b1
    } t_cmd_e;

    typedef enum logic [1:0] {
        MODE_LITERAL = 2'd0,
        MODE_COUNT15 = 2'd1,
        MODE_COUNT_HI = 2'd2,
        MODE_COUNT_LO = 2'd3
    } t_mode_e;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_WALK   = 2'd1,
        ST_FINISH = 2'd2
    } t_state_e;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // write one tree word
        logic start;   // latch a code byte and read the node for its first bit
        logic step;    // process the node read for the current bit
        logic issue;   // read the node for the next bit as part of the step
        logic finish;  // close the byte: flag the held run, apply stream end
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic step_block;
        logic finish_block;
    } t_dp_stat;

    function automatic logic [TREE_AW-1:0] to_tree_addr(input logic [15:0] v);
        return v[TREE_AW-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/hrd_ctrl.sv =====
`default_nettype none

module hrd_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_cmd,
    output logic                   o_in_ready,
    input  wire hrd_pkg::t_dp_stat i_stat,
    output hrd_pkg::t_dp_cmd       o_cmd
);

    hrd_pkg::t_state_e r_state, n_state;
    logic [2:0]        r_bit_cnt, n_bit_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hrd_pkg::ST_IDLE;
            r_bit_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_bit_cnt <= n_bit_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_bit_cnt  = r_bit_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            hrd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_cmd == hrd_pkg::CMD_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_bit_cnt   = '0;
                        n_state     = hrd_pkg::ST_WALK;
                    end
                end
            end
            hrd_pkg::ST_WALK: begin
                if (!i_stat.step_block) begin
                    o_cmd.step  = 1'b1;
                    o_cmd.issue = (r_bit_cnt != 3'd7);
                    n_bit_cnt   = r_bit_cnt + 3'd1;
                    if (r_bit_cnt == 3'd7) begin
                        n_state = hrd_pkg::ST_FINISH;
                    end
                end
            end
            hrd_pkg::ST_FINISH: begin
                if (!i_stat.finish_block) begin
                    o_cmd.finish = 1'b1;
                    n_state      = hrd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hrd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/hrd_datapath.sv =====
`default_nettype none

module hrd_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire hrd_pkg::t_dp_cmd                  i_cmd,
    output hrd_pkg::t_dp_stat                      o_stat,
    input  wire logic [hrd_pkg::IN_DATA_W-1:0]     i_in_data,
    input  wire logic                              i_in_final,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [hrd_pkg::OUT_DATA_W-1:0]         o_out_data,
    output logic                                   o_out_last,
    output logic                                   o_out_end
);

    // Code tree store, one write port and one registered read port.
    logic [15:0] r_tree [hrd_pkg::TREE_WORDS];
    logic [15:0] r_rdata;

    logic [hrd_pkg::TREE_AW-1:0] r_pos, n_pos;
    hrd_pkg::t_mode_e            r_mode, n_mode;
    logic [7:0]                  r_last_lit, n_last_lit;
    logic [7:0]                  r_count_high, n_count_high;
    logic [7:0]                  r_bits;
    logic                        r_final;

    // Run held back until it is known whether it is the last one of the byte.
    logic        r_pend_valid;
    logic [7:0]  r_pend_value;
    logic [15:0] r_pend_count;

    logic        r_m_valid;
    logic [7:0]  r_m_value;
    logic [15:0] r_m_count;
    logic        r_m_last;
    logic        r_m_end;

    logic [hrd_pkg::TREE_AW-1:0] wr_addr, rd_addr, walk_pos;
    logic                        rd_en, rd_bit;
    logic                        leaf;
    logic [7:0]                  low;
    logic                        run_fire;
    logic [7:0]                  run_value;
    logic [15:0]                 run_count;
    logic                        out_free;
    logic                        push_out;

    assign wr_addr = hrd_pkg::to_tree_addr(
        {6'd0, i_in_data[hrd_pkg::IDX_LSB +: 10]});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tree[wr_addr] <= i_in_data[hrd_pkg::WORD_LSB +: 16];
        end
        if (rd_en) begin
            r_rdata <= r_tree[rd_addr];
        end
    end

    assign leaf = r_rdata[15];
    assign low  = r_rdata[7:0];

    // Leaf decoding: run-length state and the run the current node yields.
    always_comb begin
        n_mode       = r_mode;
        n_last_lit   = r_last_lit;
        n_count_high = r_count_high;
        run_fire     = 1'b0;
        run_value    = r_last_lit;
        run_count    = 16'd0;
        if (leaf) begin
            unique case (r_mode)
                hrd_pkg::MODE_LITERAL: begin
                    if (r_rdata[14:8] == 7'd0) begin
                        n_last_lit = low;
                        run_fire   = 1'b1;
                        run_value  = low;
                        run_count  = 16'd1;
                    end else if (low == hrd_pkg::ARM_COUNT15) begin
                        n_mode = hrd_pkg::MODE_COUNT15;
                    end else if (low == hrd_pkg::ARM_COUNT16) begin
                        n_mode = hrd_pkg::MODE_COUNT_HI;
                    end else begin
                        run_fire  = 1'b1;
                        run_count = {8'd0, low};
                    end
                end
                hrd_pkg::MODE_COUNT15: begin
                    run_count = {1'b0, r_rdata[14:0]};
                    run_fire  = (r_rdata[14:0] != 15'd0);
                    n_mode    = hrd_pkg::MODE_LITERAL;
                end
                hrd_pkg::MODE_COUNT_HI: begin
                    n_count_high = low;
                    n_mode       = hrd_pkg::MODE_COUNT_LO;
                end
                hrd_pkg::MODE_COUNT_LO: begin
                    run_count = {r_count_high, low};
                    run_fire  = ({r_count_high, low} != 16'd0);
                    n_mode    = hrd_pkg::MODE_LITERAL;
                end
                default: begin
                    n_mode = hrd_pkg::MODE_LITERAL;
                end
            endcase
        end
    end

    // Walk position after the current node, then the address for the next bit.
    always_comb begin
        n_pos = leaf ? '0 : hrd_pkg::to_tree_addr({1'b0, r_rdata[15:1]});
        if (i_cmd.start) begin
            walk_pos = r_pos;
            rd_bit   = i_in_data[hrd_pkg::BYTE_LSB + 7];
        end else begin
            walk_pos = n_pos;
            rd_bit   = r_bits[7];
        end
        rd_addr = walk_pos + {{(hrd_pkg::TREE_AW-1){1'b0}}, rd_bit};
        rd_en   = i_cmd.start || (i_cmd.step && i_cmd.issue);
    end

    assign out_free            = !r_m_valid || i_out_ready;
    assign o_stat.step_block   = leaf && run_fire && r_pend_valid && !out_free;
    assign o_stat.finish_block = r_pend_valid && !out_free;
    assign push_out            = r_pend_valid
                                 && ((i_cmd.step && leaf && run_fire) || i_cmd.finish);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_mode       <= hrd_pkg::MODE_LITERAL;
            r_last_lit   <= '0;
            r_count_high <= '0;
            r_pend_valid <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_bits  <= {i_in_data[hrd_pkg::BYTE_LSB +: 7], 1'b0};
                r_final <= i_in_final;
            end
            if (i_cmd.step) begin
                r_bits       <= {r_bits[6:0], 1'b0};
                r_pos        <= n_pos;
                r_mode       <= n_mode;
                r_last_lit   <= n_last_lit;
                r_count_high <= n_count_high;
                if (leaf && run_fire) begin
                    r_pend_valid <= 1'b1;
                    r_pend_value <= run_value;
                    r_pend_count <= run_count;
                end
            end
            if (i_cmd.finish) begin
                r_pend_valid <= 1'b0;
                if (r_final) begin
                    r_pos  <= '0;
                    r_mode <= hrd_pkg::MODE_LITERAL;
                end
            end
            if (push_out) begin
                r_m_valid <= 1'b1;
                r_m_value <= r_pend_value;
                r_m_count <= r_pend_count;
                r_m_last  <= i_cmd.finish;
                r_m_end   <= i_cmd.finish && r_final;
            end else if (i_out_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_m_valid;
    assign o_out_data  = {r_m_count, r_m_value};
    assign o_out_last  = r_m_last;
    assign o_out_end   = r_m_end;

endmodule

`default_nettype wire

// ===== src/huffman_rle_decoder.sv =====
`default_nettype none

// Channel  Dir  Word contents (lowest bit first)                     tlast         tuser
// s_axis   in   tree_index[9:0] tree_word[25:10] code_byte[33:26]    final_byte    command
//               bits 39:34 are zero
// m_axis   out  run_value[7:0] run_count[23:8]                       last_of_item  stream_end
//
// A load word is taken whenever the controller is idle. A decode word walks the code
// tree one bit per cycle while no step stalls, the walk being set by the registered
// read port of the tree memory: the first node is read as the word is taken, then come
// eight steps and a closing step. A step stalls when a new run meets a held run
// that the full output register cannot take; the closing step stalls likewise.
// Reset (i_rst_n, synchronous) clears walk and run-length state, not the tree memory.

module huffman_rle_decoder (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tree_index[9:0], tree_word[25:10], code_byte[33:26], zero fill above
    input  wire logic [hrd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  wire logic                              s_axis_tlast,
    // command
    input  wire logic                              s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // run_value[7:0], run_count[23:8]
    output logic [hrd_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    output logic                                   m_axis_tlast,
    // stream_end
    output logic                                   m_axis_tuser
);

    hrd_pkg::t_dp_cmd  cmd;
    hrd_pkg::t_dp_stat stat;

    // The controller sequences load, walk and close; it never looks at the data.
    hrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath holds the tree memory, walk position, run-length state,
    // one held run and the output register.
    hrd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (s_axis_tdata),
        .i_in_final  (s_axis_tlast),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_end   (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== test/huffman_rle_decoder_tb.sv =====
`timescale 1ns / 100ps

// Tracks the code tree and the run-length state exactly as the decoder should,
// and holds the runs that accepted code bytes are due to produce.
class run_predictor;

    // Leaf values below this are literals.
    localparam logic [14:0] LITERAL_LIMIT = 15'h100;

    typedef struct {
        logic [7:0]  value;
        logic [15:0] count;
        logic        item_end;
        logic        stream_end;
    } t_run;

    logic [15:0]                 tree_mem [hrd_pkg::TREE_WORDS];
    logic [hrd_pkg::TREE_AW-1:0] walk_pos;
    hrd_pkg::t_mode_e            mode;
    logic [7:0]                  last_lit;
    logic [7:0]                  count_hi;
    t_run                        byte_runs[$];
    t_run                        runs_due[$];
    int                          errors;

    function new();
        walk_pos = '0;
        mode     = hrd_pkg::MODE_LITERAL;
        last_lit = '0;
        count_hi = '0;
        errors   = 0;
    endfunction

    function void add_run(logic [7:0] value, logic [15:0] count);
        // Runs of zero length never leave the block.
        if (count != 0)
            byte_runs.push_back('{value, count, 1'b0, 1'b0});
    endfunction

    function int pending();
        return runs_due.size();
    endfunction

    function void take_word(hrd_pkg::t_cmd_e cmd, logic [hrd_pkg::TREE_AW-1:0] idx,
                            logic [15:0] tree_word, logic [7:0] code_byte,
                            logic final_byte);
        int          b;
        logic [15:0] node;
        logic [14:0] leaf;
        if (cmd == hrd_pkg::CMD_LOAD) begin
            tree_mem[idx] = tree_word;
            return;
        end
        byte_runs.delete();
        for (b = 7; b >= 0; b--) begin
            // A one bit moves to the right sibling; positions wrap at the store depth.
            if (code_byte[b])
                walk_pos = walk_pos + 1'b1;
            node = tree_mem[walk_pos];
            if (!node[15]) begin
                walk_pos = node[hrd_pkg::TREE_AW:1];
            end else begin
                leaf = node[14:0];
                unique case (mode)
                    hrd_pkg::MODE_LITERAL: begin
                        if (leaf < LITERAL_LIMIT) begin
                            last_lit = leaf[7:0];
                            add_run(last_lit, 16'd1);
                        end else if (leaf[7:0] == hrd_pkg::ARM_COUNT15) begin
                            mode = hrd_pkg::MODE_COUNT15;
                        end else if (leaf[7:0] == hrd_pkg::ARM_COUNT16) begin
                            mode = hrd_pkg::MODE_COUNT_HI;
                        end else begin
                            add_run(last_lit, {8'h00, leaf[7:0]});
                        end
                    end
                    hrd_pkg::MODE_COUNT15: begin
                        add_run(last_lit, {1'b0, leaf});
                        mode = hrd_pkg::MODE_LITERAL;
                    end
                    hrd_pkg::MODE_COUNT_HI: begin
                        count_hi = leaf[7:0];
                        mode     = hrd_pkg::MODE_COUNT_LO;
                    end
                    default: begin
                        add_run(last_lit, {count_hi, leaf[7:0]});
                        mode = hrd_pkg::MODE_LITERAL;
                    end
                endcase
                walk_pos = '0;
            end
        end
        // Only the last run of a byte carries the byte's flags.
        if (byte_runs.size() > 0) begin
            byte_runs[byte_runs.size()-1].item_end   = 1'b1;
            byte_runs[byte_runs.size()-1].stream_end = final_byte;
        end
        if (final_byte) begin
            walk_pos = '0;
            mode     = hrd_pkg::MODE_LITERAL;
        end
        foreach (byte_runs[i])
            runs_due.push_back(byte_runs[i]);
    endfunction

    function void check_run(logic [7:0] value, logic [15:0] count, logic item_end,
                            logic stream_end);
        t_run due;
        if (runs_due.size() == 0) begin
            $error("unexpected run: run_value %0h run_count %0d", value, count);
            errors++;
            return;
        end
        due = runs_due.pop_front();
        if (value !== due.value) begin
            $error("run_value: expected %0h, got %0h", due.value, value);
            errors++;
        end
        if (count !== due.count) begin
            $error("run_count: expected %0d, got %0d", due.count, count);
            errors++;
        end
        if (item_end !== due.item_end) begin
            $error("last_of_item: expected %0b, got %0b", due.item_end, item_end);
            errors++;
        end
        if (stream_end !== due.stream_end) begin
            $error("stream_end: expected %0b, got %0b", due.stream_end, stream_end);
            errors++;
        end
    endfunction

endclass

module huffman_rle_decoder_tb;

    // Generous bound on the whole run; a correct decoder finishes far below it.
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int          PHASE_ITEMS  = 100;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          TREE_AW      = hrd_pkg::TREE_AW;
    localparam int          TREE_WORDS   = hrd_pkg::TREE_WORDS;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // tree_index[9:0], tree_word[25:10], code_byte[33:26], zero fill above
    logic [hrd_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                           s_axis_tlast  = 1'b0;   // final_byte
    logic                           s_axis_tuser  = 1'b0;   // command
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // run_value[7:0], run_count[23:8]
    logic [hrd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tlast;           // last_of_item
    logic                           m_axis_tuser;           // stream_end

    run_predictor book = new();

    // Idle and stall chances in percent; changed per phase by the stimulus.
    int          send_idle   = 0;
    int          recv_stall  = 0;
    int unsigned cycle_count = 0;
    // Base positions of the child pairs in the current code tree.
    int          bases[4];

    huffman_rle_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // The receiver stalls at random with the chance of the current phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
    end

    // Watch both channels. All signals change by nonblocking assignment at the
    // edge, so what is read here is the value that the edge itself sampled.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            book.take_word(hrd_pkg::t_cmd_e'(s_axis_tuser),
                           s_axis_tdata[hrd_pkg::IDX_LSB +: TREE_AW],
                           s_axis_tdata[hrd_pkg::WORD_LSB +: 16],
                           s_axis_tdata[hrd_pkg::BYTE_LSB +: 8], s_axis_tlast);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            book.check_run(m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tlast, m_axis_tuser);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offers one word and returns at the edge that accepts it. Called right
    // after a rising edge; tvalid stays high when the next word follows at once.
    task automatic send_word(input hrd_pkg::t_cmd_e cmd, input logic [TREE_AW-1:0] idx,
                             input logic [15:0] tree_word, input logic [7:0] code_byte,
                             input logic final_byte);
        while ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, code_byte, tree_word, idx};
        s_axis_tlast  <= final_byte;
        s_axis_tuser  <= cmd;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
    endtask

    // The fields a word does not use carry random values; the block must ignore them.
    task automatic load_word(input logic [TREE_AW-1:0] idx, input logic [15:0] tree_word);
        send_word(hrd_pkg::CMD_LOAD, idx, tree_word, 8'($urandom),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic decode_byte(input logic [7:0] code_byte, input logic final_byte);
        send_word(hrd_pkg::CMD_DECODE, TREE_AW'($urandom), 16'($urandom), code_byte,
                  final_byte);
    endtask

    // A leaf whose value is a literal, a control code or an arbitrary count.
    function automatic logic [15:0] make_leaf();
        int          pick;
        logic [14:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            v = 15'($urandom_range(0, 255));
        else if (pick < 52)
            v = {7'($urandom_range(1, 127)), hrd_pkg::ARM_COUNT15};
        else if (pick < 64)
            v = {7'($urandom_range(1, 127)), hrd_pkg::ARM_COUNT16};
        else if (pick < 72)
            v = '0;
        else
            v = 15'($urandom);
        return {1'b1, v};
    endfunction

    // An inner node naming the pair at base; the upper index bits are dropped
    // by the block, so they are filled at random to exercise that wrap.
    function automatic logic [15:0] make_inner(input int base);
        return {1'b0, 4'($urandom_range(0, 15)), TREE_AW'(base), 1'($urandom_range(0, 1))};
    endfunction

    // Loads a fresh tree of four child pairs. Pairs point only to later pairs,
    // so a walk always ends in a leaf, and every position a walk can reach has
    // been written. The root pair sits at zero; a pair at the top of the store
    // wraps onto position zero.
    task automatic build_tree();
        int k;
        int j;
        bases[0] = 0;
        for (k = 1; k < 4; k++)
            bases[k] = ($urandom_range(0, 3) == 0) ? TREE_WORDS - 1
                                                   : $urandom_range(0, TREE_WORDS - 1);
        for (k = 0; k < 4; k++) begin
            load_word(TREE_AW'(bases[k]), make_leaf());
            load_word(TREE_AW'(bases[k] + 1), make_leaf());
        end
        for (k = 0; k < 3; k++)
            for (j = 0; j < 2; j++)
                if ($urandom_range(0, 99) < 40)
                    load_word(TREE_AW'(bases[k] + j), make_inner(bases[$urandom_range(k + 1, 3)]));
    endtask

    // Mostly code bytes, now and then a stream end, and a few tree rewrites
    // anywhere in the store that keep all reachable positions written.
    task automatic run_phase(input int items);
        int i;
        for (i = 0; i < items; i++) begin
            if ($urandom_range(0, 99) < 6)
                load_word(TREE_AW'($urandom), $urandom_range(0, 1)
                          ? make_leaf() : make_inner(bases[$urandom_range(0, 3)]));
            else
                decode_byte(8'($urandom), $urandom_range(0, 99) < 8);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. With both root children leaves, every bit of a byte
        // picks a leaf directly: zero selects position 0, one selects position 1.
        load_word(TREE_AW'(0), 16'h8041);        // literal 0x41
        load_word(TREE_AW'(1), 16'h8100);        // arms a 15-bit count
        decode_byte(8'h00, 1'b0);                // eight literals, the most runs per byte
        decode_byte(8'h40, 1'b0);                // literal, count of 0x41, literals
        load_word(TREE_AW'(0), 16'hFFFF);
        decode_byte(8'h40, 1'b0);                // repeats of 255 and a count of 0x7FFF
        load_word(TREE_AW'(1), 16'h8101);        // arms a two-leaf count
        decode_byte(8'h40, 1'b0);                // count 0xFFFF, the largest run
        load_word(TREE_AW'(0), 16'h8000);        // literal zero
        decode_byte(8'h40, 1'b0);                // two-leaf count of zero is dropped
        load_word(TREE_AW'(1), 16'h8100);
        decode_byte(8'h40, 1'b0);                // 15-bit count of zero is dropped
        decode_byte(8'h01, 1'b1);                // stream ends with a count still armed
        decode_byte(8'h00, 1'b0);                // must start in literal mode again
        load_word(TREE_AW'(TREE_WORDS - 1), 16'h8042);
        load_word(TREE_AW'(0), 16'h7FFF);        // inner node whose pair wraps past the top
        decode_byte(8'h40, 1'b0);                // walks across the wrap, ends mid-tree
        decode_byte(8'h80, 1'b1);                // resumes the walk, then ends the stream
        load_word(TREE_AW'(0), 16'h0000);        // inner node pointing at its own pair
        decode_byte(8'h00, 1'b1);                // no leaf at all: a final byte with no runs
        load_word(TREE_AW'(0), 16'h80FF);
        decode_byte(8'h7F, 1'b1);
        decode_byte(8'hFF, 1'b0);

        // Random part in four idling phases: none, sender idle, receiver
        // stalling, and both at once.
        send_idle = 0;  recv_stall = 0;
        build_tree();
        run_phase(PHASE_ITEMS);
        send_idle = 60; recv_stall = 0;
        build_tree();
        run_phase(PHASE_ITEMS);
        send_idle = 0;  recv_stall = 60;
        build_tree();
        run_phase(PHASE_ITEMS);
        send_idle = 26; recv_stall = 26;
        build_tree();
        run_phase(PHASE_ITEMS);
        s_axis_tvalid <= 1'b0;

        // Drain, then allow a few byte times for any stray run to show up.
        while (book.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (book.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
